// ===== hdl/brn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brn_pkg
// Shared constants, codes and pipeline tag types of the residual normalizer.
// ----------------------------------------------------------------------------
package brn_pkg;

   localparam int CHARGES_DEF        = 2;
   localparam int ARMS_DEF           = 2;
   localparam int ZED_BINS_DEF       = 8;
   localparam int CENT_BINS_DEF      = 8;
   localparam int PT_BINS_DEF        = 13;
   localparam int HIGH_TEST_BINS_DEF = 2;
   localparam int STAGES             = 3;
   localparam int KINDS              = 2;

   localparam logic [11:0] PT_CLAMP_MEV = 12'd2980;

   // function codes
   localparam logic [1:0] FUNC_WR_MEAN  = 2'd0;
   localparam logic [1:0] FUNC_WR_WIDTH = 2'd1;
   localparam logic [1:0] FUNC_COMPUTE  = 2'd2;
   localparam logic [1:0] FUNC_NONE     = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BELOW  = 2'd1;
   localparam logic [1:0] ST_ZERO_W = 2'd2;
   localparam logic [1:0] ST_WRITE  = 2'd3;

   // bin lower edges and centers in MeV
   localparam logic [15:0] EDGE_LO [PT_BINS_DEF] = '{
      16'd200, 16'd400, 16'd600, 16'd800, 16'd1000, 16'd1200, 16'd1400,
      16'd1600, 16'd1800, 16'd2000, 16'd2500, 16'd3000, 16'd10000};
   localparam logic [15:0] CENTER [PT_BINS_DEF] = '{
      16'd300, 16'd500, 16'd700, 16'd900, 16'd1100, 16'd1300, 16'd1500,
      16'd1700, 16'd1900, 16'd2250, 16'd2750, 16'd6500, 16'd17500};

   // interpolation divider: bin spacing below 2^12, quotient below 2^35
   localparam int IDIV_DEN_W = 12;
   localparam int IDIV_QUO_W = 35;
   // normalizing divider
   localparam int NDIV_DEN_W = 32;
   localparam int NDIV_QUO_W = 32;

   typedef struct packed {
      logic               valid;
      logic [1:0]         status;
      logic signed [31:0] value;
      logic signed [31:0] y0;
      logic               neg;
   } brn_mtag_type;

   typedef struct packed {
      logic signed [31:0] y0;
      logic               neg;
   } brn_wtag_type;

   typedef struct packed {
      logic               valid;
      logic [1:0]         status;
      logic signed [31:0] mean;
      logic signed [31:0] width;
      logic               neg;
      logic               ovf;
   } brn_ntag_type;

   function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
      logic signed [31:0] r;
      if (v > 37'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -37'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/brn_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brn_ram
// Generic RAM, one write port, two registered read ports.
// ----------------------------------------------------------------------------
module brn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_a,
   output logic [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== hdl/brn_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brn_div
// Pipelined restoring divider, one quotient bit per stage, with sideband tag.
// Requires num < den * 2^QUO_W.
// ----------------------------------------------------------------------------
module brn_div #(
   parameter int DEN_W = 12,
   parameter int QUO_W = 35,
   parameter int TAG_W = 1,
   localparam int REM_W = DEN_W + QUO_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic [REM_W-1:0] num_in,
   input  logic [DEN_W-1:0] den_in,
   input  logic [TAG_W-1:0] tag_in,
   output logic [QUO_W-1:0] quo_out,
   output logic [TAG_W-1:0] tag_out
);

   logic [REM_W-1:0] rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [TAG_W-1:0] tag_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      logic [REM_W-1:0] rem_src;
      logic [DEN_W-1:0] den_src;
      logic [QUO_W-1:0] quo_src;
      logic [TAG_W-1:0] tag_src;
      logic [REM_W-1:0] shifted;
      logic [REM_W:0]   trial;
      logic [REM_W-1:0] rem_in;
      logic [QUO_W-1:0] quo_in;

      if (k == 0) begin : g_first
         assign rem_src = num_in;
         assign den_src = den_in;
         assign quo_src = '0;
         assign tag_src = tag_in;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign quo_src = quo_ff[k-1];
         assign tag_src = tag_ff[k-1];
      end

      always_comb begin
         shifted = REM_W'(den_src) << (QUO_W - 1 - k);
         trial   = {1'b0, rem_src} - {1'b0, shifted};
         if (trial[REM_W]) begin
            rem_in = rem_src;
            quo_in = quo_src;
         end else begin
            rem_in = trial[REM_W-1:0];
            quo_in = quo_src | (QUO_W'(1) << (QUO_W - 1 - k));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k] <= '0;
         end else if (enable) begin
            tag_ff[k] <= tag_src;
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_src;
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign quo_out = quo_ff[QUO_W-1];
   assign tag_out = tag_ff[QUO_W-1];

endmodule

// ===== hdl/binned_residual_normalizer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binned_residual_normalizer_top
// Momentum-binned calibration tables with linear interpolation of mean and
// width, and a normalized residual (value - mean) / width in Q16.16.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while no response is held; the table RAMs are read on the accept
//   cycle and both dividers are fully pipelined, one quotient bit per stage.
// The whole pipeline freezes only while a response is held by rsp_stall.
// Reset clears the pipeline valid bits; table contents are undefined until
//   written, there is no clearing pass.
// ----------------------------------------------------------------------------
module binned_residual_normalizer_top
   import brn_pkg::*;
#(
   parameter int CHARGES        = CHARGES_DEF,
   parameter int ARMS           = ARMS_DEF,
   parameter int ZED_BINS       = ZED_BINS_DEF,
   parameter int CENT_BINS      = CENT_BINS_DEF,
   parameter int PT_BINS        = PT_BINS_DEF,
   parameter int HIGH_TEST_BINS = HIGH_TEST_BINS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic               req_charge,
   input  logic               req_arm,
   input  logic [2:0]         req_zed_bin,
   input  logic [2:0]         req_cent_bin,
   input  logic [3:0]         req_pt_bin,
   input  logic [1:0]         req_stage,
   input  logic               req_kind,
   input  logic [15:0]        req_pt_mev,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_deviation,
   output logic signed [31:0] rsp_mean_used,
   output logic signed [31:0] rsp_width_used,
   output logic [1:0]         rsp_status
);

   localparam int DEPTH  = CHARGES * ARMS * ZED_BINS * CENT_BINS * PT_BINS * STAGES * KINDS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int LAST_LO_BIN = PT_BINS - HIGH_TEST_BINS - 1;
   localparam int IREM_W = IDIV_DEN_W + IDIV_QUO_W;
   localparam int NREM_W = NDIV_DEN_W + NDIV_QUO_W;

   // ---------------------------------------------------------------------
   // Handshake: every stage moves together unless the response is held.
   // ---------------------------------------------------------------------
   logic advance;
   logic accept;
   logic rsp_valid_ff;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   // ---------------------------------------------------------------------
   // Accept cycle: bin search, neighbor choice, table addresses.
   // ---------------------------------------------------------------------
   logic [11:0]       p_clamp;
   logic              below;
   logic [3:0]        bin;
   logic              up_side;
   logic [3:0]        lo;
   logic [15:0]       x0;
   logic [15:0]       x1;
   logic signed [16:0] pdiff_full;
   logic [11:0]       dx;
   logic              oor_common;
   logic              oor_wr;
   logic [ADDR_W-1:0] head_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr0;
   logic [ADDR_W-1:0] rd_addr1;
   logic              wr_mean;
   logic              wr_width;

   always_comb begin
      p_clamp = (req_pt_mev > 16'(PT_CLAMP_MEV)) ? PT_CLAMP_MEV : req_pt_mev[11:0];
      below   = {4'b0, p_clamp} < EDGE_LO[0];
      // bin = number of higher lower-edges reached (independent compares)
      bin = '0;
      for (int i = 1; i < PT_BINS; i++) begin
         if ({4'b0, p_clamp} >= EDGE_LO[i]) begin
            bin = bin + 4'd1;
         end
      end
      up_side = ((bin == 4'd0) || ({4'b0, p_clamp} >= CENTER[bin]))
                && (32'(bin) != LAST_LO_BIN);
      if (up_side) begin
         lo = bin;
      end else if (bin == 4'd0) begin
         lo = 4'd0;
      end else begin
         lo = bin - 4'd1;
      end
      if (32'(lo) > PT_BINS - 2) begin
         lo = 4'(PT_BINS - 2);
      end
      x0         = CENTER[lo];
      x1         = CENTER[lo + 4'd1];
      pdiff_full = $signed({5'b0, p_clamp}) - $signed({1'b0, x0});
      dx         = 12'(x1 - x0);
   end

   always_comb begin
      oor_common = (32'(req_charge) >= CHARGES) || (32'(req_arm) >= ARMS)
                || (32'(req_zed_bin) >= ZED_BINS) || (32'(req_cent_bin) >= CENT_BINS)
                || (32'(req_stage) >= STAGES) || (32'(req_kind) >= KINDS);
      oor_wr     = oor_common || (32'(req_pt_bin) >= PT_BINS);
      head_addr  = ((ADDR_W'(req_charge) * ADDR_W'(ARMS) + ADDR_W'(req_arm))
                    * ADDR_W'(ZED_BINS) + ADDR_W'(req_zed_bin))
                   * ADDR_W'(CENT_BINS) + ADDR_W'(req_cent_bin);
      wr_addr    = ((head_addr * ADDR_W'(PT_BINS) + ADDR_W'(req_pt_bin))
                    * ADDR_W'(STAGES) + ADDR_W'(req_stage)) * ADDR_W'(KINDS)
                   + ADDR_W'(req_kind);
      rd_addr0   = ((head_addr * ADDR_W'(PT_BINS) + ADDR_W'(lo))
                    * ADDR_W'(STAGES) + ADDR_W'(req_stage)) * ADDR_W'(KINDS)
                   + ADDR_W'(req_kind);
      rd_addr1   = rd_addr0 + ADDR_W'(STAGES * KINDS);
      wr_mean    = accept && (req_func == FUNC_WR_MEAN) && !oor_wr;
      wr_width   = accept && (req_func == FUNC_WR_WIDTH) && !oor_wr;
   end

   // Writes land at accept; a later compute reads at its own accept, so no
   // compute reads an entry while it is being written.
   logic [31:0] mean_rd0;
   logic [31:0] mean_rd1;
   logic [31:0] width_rd0;
   logic [31:0] width_rd1;

   brn_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_mean_ram (
      .clock     (clock),
      .wr_en     (wr_mean),
      .wr_addr   (wr_addr),
      .wr_data   (req_value),
      .rd_en     (advance),
      .rd_addr_a (rd_addr0),
      .rd_addr_b (rd_addr1),
      .rd_data_a (mean_rd0),
      .rd_data_b (mean_rd1)
   );

   brn_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_width_ram (
      .clock     (clock),
      .wr_en     (wr_width),
      .wr_addr   (wr_addr),
      .wr_data   (req_value),
      .rd_en     (advance),
      .rd_addr_a (rd_addr0),
      .rd_addr_b (rd_addr1),
      .rd_data_a (width_rd0),
      .rd_data_b (width_rd1)
   );

   // ---------------------------------------------------------------------
   // Stage 1: registered alongside the RAM read.
   // ---------------------------------------------------------------------
   logic               s1_valid_ff;
   logic [1:0]         s1_status_ff;
   logic               s1_oor_ff;
   logic signed [11:0] s1_pdiff_ff;
   logic [11:0]        s1_dx_ff;
   logic signed [31:0] s1_value_ff;
   logic [1:0]         s1_status_in;

   always_comb begin
      if (req_func == FUNC_COMPUTE) begin
         s1_status_in = below ? ST_BELOW : ST_OK;
      end else begin
         s1_status_in = ST_WRITE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= accept && (req_func != FUNC_NONE);
         s1_status_ff <= s1_status_in;
         s1_oor_ff    <= oor_common;
         s1_pdiff_ff  <= pdiff_full[11:0];
         s1_dx_ff     <= dx;
         s1_value_ff  <= req_value;
      end
   end

   // Stage 1 logic: slope products (p - x0) * (y1 - y0).
   logic signed [31:0] ym0;
   logic signed [31:0] ym1;
   logic signed [31:0] yw0;
   logic signed [31:0] yw1;
   logic signed [32:0] dym;
   logic signed [32:0] dyw;
   logic signed [44:0] prod_m;
   logic signed [44:0] prod_w;

   always_comb begin
      // out-of-range points read as zero
      ym0 = s1_oor_ff ? '0 : mean_rd0;
      ym1 = s1_oor_ff ? '0 : mean_rd1;
      yw0 = s1_oor_ff ? '0 : width_rd0;
      yw1 = s1_oor_ff ? '0 : width_rd1;
      dym = {ym1[31], ym1} - {ym0[31], ym0};
      dyw = {yw1[31], yw1} - {yw0[31], yw0};
      prod_m = $signed({{33{s1_pdiff_ff[11]}}, s1_pdiff_ff})
             * $signed({{12{dym[32]}}, dym});
      prod_w = $signed({{33{s1_pdiff_ff[11]}}, s1_pdiff_ff})
             * $signed({{12{dyw[32]}}, dyw});
   end

   // ---------------------------------------------------------------------
   // Stage 2: products registered.
   // ---------------------------------------------------------------------
   logic               s2_valid_ff;
   logic [1:0]         s2_status_ff;
   logic signed [44:0] s2_prod_m_ff;
   logic signed [44:0] s2_prod_w_ff;
   logic signed [31:0] s2_ym0_ff;
   logic signed [31:0] s2_yw0_ff;
   logic [11:0]        s2_dx_ff;
   logic signed [31:0] s2_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff  <= s1_valid_ff;
         s2_status_ff <= s1_status_ff;
         s2_prod_m_ff <= prod_m;
         s2_prod_w_ff <= prod_w;
         s2_ym0_ff    <= ym0;
         s2_yw0_ff    <= yw0;
         s2_dx_ff     <= s1_dx_ff;
         s2_value_ff  <= s1_value_ff;
      end
   end

   // Magnitude plus half the spacing gives round-half-away on the quotient.
   logic              neg_m;
   logic              neg_w;
   logic [44:0]       abs_m;
   logic [44:0]       abs_w;
   logic [IREM_W-1:0] inum_m;
   logic [IREM_W-1:0] inum_w;
   brn_mtag_type      mtag_in;
   brn_wtag_type      wtag_in;

   always_comb begin
      neg_m  = s2_prod_m_ff < 0;
      neg_w  = s2_prod_w_ff < 0;
      abs_m  = neg_m ? 45'(-s2_prod_m_ff) : s2_prod_m_ff;
      abs_w  = neg_w ? 45'(-s2_prod_w_ff) : s2_prod_w_ff;
      inum_m = IREM_W'(abs_m) + IREM_W'(s2_dx_ff >> 1);
      inum_w = IREM_W'(abs_w) + IREM_W'(s2_dx_ff >> 1);
      mtag_in.valid  = s2_valid_ff;
      mtag_in.status = s2_status_ff;
      mtag_in.value  = s2_value_ff;
      mtag_in.y0     = s2_ym0_ff;
      mtag_in.neg    = neg_m;
      wtag_in.y0     = s2_yw0_ff;
      wtag_in.neg    = neg_w;
   end

   logic [IDIV_QUO_W-1:0] iquo_m;
   logic [IDIV_QUO_W-1:0] iquo_w;
   brn_mtag_type          mtag_out;
   brn_wtag_type          wtag_out;

   brn_div #(
      .DEN_W (IDIV_DEN_W),
      .QUO_W (IDIV_QUO_W),
      .TAG_W ($bits(brn_mtag_type))
   ) u_mean_div (
      .clock   (clock),
      .reset   (reset),
      .enable  (advance),
      .num_in  (inum_m),
      .den_in  (s2_dx_ff),
      .tag_in  (mtag_in),
      .quo_out (iquo_m),
      .tag_out (mtag_out)
   );

   brn_div #(
      .DEN_W (IDIV_DEN_W),
      .QUO_W (IDIV_QUO_W),
      .TAG_W ($bits(brn_wtag_type))
   ) u_width_div (
      .clock   (clock),
      .reset   (reset),
      .enable  (advance),
      .num_in  (inum_w),
      .den_in  (s2_dx_ff),
      .tag_in  (wtag_in),
      .quo_out (iquo_w),
      .tag_out (wtag_out)
   );

   // y0 + signed quotient, saturated.
   logic signed [36:0] delta_m;
   logic signed [36:0] delta_w;
   logic signed [31:0] mean_in;
   logic signed [31:0] width_in;

   always_comb begin
      delta_m  = mtag_out.neg ? -$signed({2'b0, iquo_m}) : $signed({2'b0, iquo_m});
      delta_w  = wtag_out.neg ? -$signed({2'b0, iquo_w}) : $signed({2'b0, iquo_w});
      mean_in  = sat32({{5{mtag_out.y0[31]}}, mtag_out.y0} + delta_m);
      width_in = sat32({{5{wtag_out.y0[31]}}, wtag_out.y0} + delta_w);
   end

   // ---------------------------------------------------------------------
   // Stage 3: interpolated mean and width registered.
   // ---------------------------------------------------------------------
   logic               s3_valid_ff;
   logic [1:0]         s3_status_ff;
   logic signed [31:0] s3_mean_ff;
   logic signed [31:0] s3_width_ff;
   logic signed [31:0] s3_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff  <= mtag_out.valid;
         s3_status_ff <= mtag_out.status;
         s3_mean_ff   <= mean_in;
         s3_width_ff  <= width_in;
         s3_value_ff  <= mtag_out.value;
      end
   end

   // Normalizing divide setup: |value - mean| * 2^16 + |width| / 2.
   // A quotient of 2^32 or more saturates either way, so it is caught here
   // and the divider only needs 32 quotient bits.
   logic signed [32:0] diff;
   logic [32:0]        abs_diff;
   logic [31:0]        den;
   logic [NREM_W-1:0]  nnum;
   logic               ovf;
   brn_ntag_type       ntag_in;

   always_comb begin
      diff     = {s3_value_ff[31], s3_value_ff} - {s3_mean_ff[31], s3_mean_ff};
      abs_diff = diff[32] ? 33'(-diff) : diff;
      den      = s3_width_ff[31] ? 32'(-s3_width_ff) : s3_width_ff;
      nnum     = NREM_W'({abs_diff, 16'b0}) + NREM_W'(den >> 1);
      ovf      = nnum >= {den, 32'b0};
      ntag_in.valid  = s3_valid_ff;
      ntag_in.status = s3_status_ff;
      if ((s3_status_ff == ST_OK) && (s3_width_ff == 0)) begin
         ntag_in.status = ST_ZERO_W;
      end
      ntag_in.mean  = s3_mean_ff;
      ntag_in.width = s3_width_ff;
      ntag_in.neg   = diff[32] ^ s3_width_ff[31];
      ntag_in.ovf   = ovf;
   end

   logic [NDIV_QUO_W-1:0] nquo;
   brn_ntag_type          ntag_out;

   brn_div #(
      .DEN_W (NDIV_DEN_W),
      .QUO_W (NDIV_QUO_W),
      .TAG_W ($bits(brn_ntag_type))
   ) u_norm_div (
      .clock   (clock),
      .reset   (reset),
      .enable  (advance),
      .num_in  (ovf ? '0 : nnum),
      .den_in  (den),
      .tag_in  (ntag_in),
      .quo_out (nquo),
      .tag_out (ntag_out)
   );

   // ---------------------------------------------------------------------
   // Output stage: sign, saturation, status masking.
   // ---------------------------------------------------------------------
   logic signed [31:0] dev;
   logic signed [31:0] rsp_dev_in;
   logic signed [31:0] rsp_mean_in;
   logic signed [31:0] rsp_width_in;

   always_comb begin
      if (ntag_out.ovf) begin
         dev = ntag_out.neg ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else if (ntag_out.neg) begin
         dev = (nquo[31] && (nquo[30:0] != '0)) ? 32'sh80000000 : 32'(-nquo);
      end else begin
         dev = nquo[31] ? 32'sh7FFFFFFF : nquo;
      end
      case (ntag_out.status)
         ST_OK: begin
            rsp_dev_in   = dev;
            rsp_mean_in  = ntag_out.mean;
            rsp_width_in = ntag_out.width;
         end
         ST_ZERO_W: begin
            rsp_dev_in   = '0;
            rsp_mean_in  = ntag_out.mean;
            rsp_width_in = ntag_out.width;
         end
         default: begin
            rsp_dev_in   = '0;
            rsp_mean_in  = '0;
            rsp_width_in = '0;
         end
      endcase
   end

   logic signed [31:0] rsp_dev_ff;
   logic signed [31:0] rsp_mean_ff;
   logic signed [31:0] rsp_width_ff;
   logic [1:0]         rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff  <= ntag_out.valid;
         rsp_dev_ff    <= rsp_dev_in;
         rsp_mean_ff   <= rsp_mean_in;
         rsp_width_ff  <= rsp_width_in;
         rsp_status_ff <= ntag_out.status;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_deviation  = rsp_dev_ff;
   assign rsp_mean_used  = rsp_mean_ff;
   assign rsp_width_used = rsp_width_ff;
   assign rsp_status     = rsp_status_ff;

`ifndef SYNTHESIS
   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_WRITE) |->
         (rsp_deviation == 0) && (rsp_mean_used == 0) && (rsp_width_used == 0))
      else $error("write response carries nonzero fields");

   a_zero_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_ZERO_W) |->
         (rsp_width_used == 0) && (rsp_deviation == 0))
      else $error("zero-width status with nonzero width or deviation");

   a_ok_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_OK) |-> (rsp_width_used != 0))
      else $error("ok status with zero width");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff)
      else $error("pipeline moved while response held");
`endif

endmodule
